>>> design/fles_pkg.sv
`timescale 1ns / 1ps

package fles_pkg;

    localparam int SECTOR_BYTES_DEF = 4096;
    localparam int PAGE_BYTES_DEF   = 256;
    localparam int ADDR_BITS_DEF    = 24;

    localparam int FIELD_W     = 24;
    localparam int LEN_W       = 9;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    typedef logic [0:0] t_reg_idx;
    localparam t_reg_idx REG_TARGET_ADDRESS = 1'b0;
    localparam t_reg_idx REG_IMAGE_BYTES    = 1'b1;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_ERASE   = 2'd1,
        CMD_PROGRAM = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        PH_INIT    = 2'd0,
        PH_ERASE   = 2'd1,
        PH_PROGRAM = 2'd2
    } t_phase;

    typedef struct packed {
        t_cmd               command;
        logic [FIELD_W-1:0] command_address;
        logic [LEN_W-1:0]   program_length;
        logic [FIELD_W-1:0] buffer_offset;
        logic               finished;
    } t_result;

endpackage

>>> design/flash_erase_program_sequencer.sv
`timescale 1ns / 1ps

// Channel   | Valid        | Stall        | Payload
// poll in   | i_in_valid   | o_in_stall   | i_flash_busy
// result    | o_out_valid  | i_out_stall  | o_command, o_command_address, o_program_length,
//           |              |              | o_buffer_offset, o_finished
// config    | psel/penable | pready (=1)  | pwrite, paddr, pwdata, prdata
//
// One poll transfer per cycle while o_in_stall is low; its result is registered into the
// output register, or into the skid register when the output stalls.
// The sequencer state is updated in the same cycle that the poll is taken.
// A skid register holds one result while the output stalls; o_in_stall rises only
// when both the output and skid registers are full.
// i_rst_n clears phase, range state, registers and valid flags synchronously.
// SECTOR_BYTES is taken as a power of two.

module flash_erase_program_sequencer
    import fles_pkg::*;
#(
    parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
    parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_flash_busy,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_command,
    output logic [FIELD_W-1:0]    o_command_address,
    output logic [LEN_W-1:0]      o_program_length,
    output logic [FIELD_W-1:0]    o_buffer_offset,
    output logic                  o_finished,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int W_W = $clog2(PAGE_BYTES + 1);
    localparam int SUM_W = FIELD_W + 1;
    localparam logic [ADDR_BITS-1:0] SECTOR_MASK =
        ADDR_BITS'(~(64'(SECTOR_BYTES) - 64'd1));
    localparam logic [ADDR_BITS-1:0] SECTOR_STEP = ADDR_BITS'(64'(SECTOR_BYTES));
    localparam logic [FIELD_W-1:0]   PAGE_LIMIT  = FIELD_W'(PAGE_BYTES);

    logic [FIELD_W-1:0]   r_target_address;
    logic [FIELD_W-1:0]   r_image_bytes;

    t_phase               r_phase, n_phase;
    logic [ADDR_BITS-1:0] r_cur, n_cur;
    logic [ADDR_BITS-1:0] r_end, n_end;
    logic [FIELD_W-1:0]   r_left, n_left;
    logic [FIELD_W-1:0]   r_src, n_src;

    t_result              r_out, r_skid, n_res;
    logic                 r_out_valid, r_skid_valid;

    logic                 in_fire, out_free, cfg_wr;
    logic [ADDR_BITS-1:0] load_cur, load_end;
    logic [SUM_W-1:0]     range_sum;
    logic [W_W-1:0]       page_w;

    assign in_fire  = i_in_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_out_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;

    assign o_in_stall        = r_skid_valid;
    assign o_out_valid       = r_out_valid;
    assign o_command         = r_out.command;
    assign o_command_address = r_out.command_address;
    assign o_program_length  = r_out.program_length;
    assign o_buffer_offset   = r_out.buffer_offset;
    assign o_finished        = r_out.finished;
    assign pready            = 1'b1;

    always_comb begin
        case (t_reg_idx'(paddr[2]))
            REG_TARGET_ADDRESS: prdata = CFG_DATA_W'(r_target_address);
            REG_IMAGE_BYTES:    prdata = CFG_DATA_W'(r_image_bytes);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_address <= '0;
            r_image_bytes    <= '0;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[2]))
                REG_TARGET_ADDRESS: r_target_address <= pwdata[FIELD_W-1:0];
                REG_IMAGE_BYTES:    r_image_bytes    <= pwdata[FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    assign range_sum = SUM_W'(r_target_address) + SUM_W'(r_image_bytes);
    assign load_cur  = ADDR_BITS'(r_target_address);
    assign load_end  = ADDR_BITS'(range_sum);
    assign page_w    = (r_left > PAGE_LIMIT) ? W_W'(PAGE_BYTES) : W_W'(r_left);

    always_comb begin
        n_phase = r_phase;
        n_cur   = r_cur;
        n_end   = r_end;
        n_left  = r_left;
        n_src   = r_src;
        n_res   = '{command: CMD_NONE, default: '0};
        if (!i_flash_busy) begin
            case (r_phase)
                PH_INIT: begin
                    n_cur   = load_cur & SECTOR_MASK;
                    n_end   = load_end & SECTOR_MASK;
                    n_left  = r_image_bytes;
                    n_src   = '0;
                    n_phase = PH_ERASE;
                end
                PH_ERASE: begin
                    n_res.command         = CMD_ERASE;
                    n_res.command_address = FIELD_W'(r_cur);
                    n_cur                 = r_cur + SECTOR_STEP;
                    if (r_cur == r_end) begin
                        n_cur   = load_cur;
                        n_end   = load_end;
                        n_left  = r_image_bytes;
                        n_src   = '0;
                        n_phase = PH_PROGRAM;
                    end
                end
                PH_PROGRAM: begin
                    n_res.command         = CMD_PROGRAM;
                    n_res.command_address = FIELD_W'(r_cur);
                    n_res.program_length  = LEN_W'(page_w);
                    n_res.buffer_offset   = r_src;
                    n_cur                 = r_cur + ADDR_BITS'(page_w);
                    n_src                 = r_src + FIELD_W'(page_w);
                    n_left                = r_left - FIELD_W'(page_w);
                    if (n_left == '0) begin
                        n_res.finished = 1'b1;
                        n_phase        = PH_INIT;
                    end
                end
                default: begin
                    n_phase = PH_INIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_INIT;
            r_cur   <= '0;
            r_end   <= '0;
            r_left  <= '0;
            r_src   <= '0;
        end else if (in_fire) begin
            r_phase <= n_phase;
            r_cur   <= n_cur;
            r_end   <= n_end;
            r_left  <= n_left;
            r_src   <= n_src;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid  <= r_skid_valid || in_fire;
                r_skid_valid <= 1'b0;
            end else if (in_fire) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_fire) begin
                r_out <= n_res;
            end
        end
        if (in_fire && (r_skid_valid || !out_free)) begin
            r_skid <= n_res;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while output register is empty");

    a_finish_on_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.finished) |-> (r_out.command == CMD_PROGRAM))
        else $error("finished reported without a page program");

    a_busy_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_flash_busy) |=> ($stable(r_phase) && $stable(r_cur) && $stable(r_left)))
        else $error("busy poll changed sequencer state");

    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.command == CMD_NONE) |->
        (r_out.command_address == '0 && r_out.program_length == '0 &&
         r_out.buffer_offset == '0 && !r_out.finished))
        else $error("idle result carries nonzero fields");

    a_erase_leads_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_phase == PH_INIT && !i_flash_busy) |=> (r_phase == PH_ERASE))
        else $error("idle poll at start did not enter erase");

endmodule
